>>> design/dpsm_pkg.sv
`default_nettype none

package dpsm_pkg;

  localparam int BASE_W = 16;
  localparam int SUM_W  = 32;

  localparam logic [BASE_W-1:0] MIN_BASE  = 16'd2;
  localparam logic [BASE_W-1:0] BASE_RST  = 16'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic mul;
    logic next_pass;
    logic store_out;
  } dpsm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trivial;
    logic last_step;
    logic quot_zero;
  } dpsm_stat_t;

endpackage

`default_nettype wire

>>> design/dpsm_in_if.sv
`default_nettype none

interface dpsm_in_if #(
  parameter int OPERAND_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  logic [OPERAND_WIDTH-1:0] left_operand;
  logic [OPERAND_WIDTH-1:0] right_operand;

  modport source (output valid, output left_operand, output right_operand, input ready);
  modport sink (input valid, input left_operand, input right_operand, output ready);
endinterface

`default_nettype wire

>>> design/dpsm_out_if.sv
`default_nettype none

interface dpsm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] digit_sum;

  modport source (output valid, output digit_sum, input ready);
  modport sink (input valid, input digit_sum, output ready);
endinterface

`default_nettype wire

>>> design/dpsm_dp.sv
`default_nettype none

module dpsm_dp
  import dpsm_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_wr_en,
  input  wire logic [BASE_W-1:0]        cfg_wr_data,
  input  wire logic [OPERAND_WIDTH-1:0] left_operand,
  input  wire logic [OPERAND_WIDTH-1:0] right_operand,
  input  wire dpsm_cmd_t                cmd,
  output dpsm_stat_t                    stat,
  output logic [BASE_W-1:0]             digit_sum
);

  localparam int DW    = (OPERAND_WIDTH > SUM_W) ? OPERAND_WIDTH : SUM_W;
  localparam int CNT_W = $clog2(DW);
  localparam int LANES = 3;

  // Lane 0 and 1 divide the operands; lane 2 reduces the running sum.
  logic [BASE_W-1:0] base;
  logic [DW-1:0]     quot [LANES];
  logic [BASE_W-1:0] rem  [LANES];
  logic [DW-1:0]     quot_next [LANES];
  logic [BASE_W-1:0] rem_next  [LANES];
  logic [CNT_W-1:0]  cnt;
  logic [SUM_W-1:0]  prod;
  logic [SUM_W-1:0]  sum;

  // One restoring division step: returns the quotient bit and the new remainder.
  function automatic logic [BASE_W:0] div_step(input logic [BASE_W:0] t,
                                               input logic [BASE_W-1:0] m);
    logic          ge;
    logic [BASE_W:0] d;
    ge = (t >= {1'b0, m});
    d  = ge ? (t - {1'b0, m}) : t;
    return {ge, d[BASE_W-1:0]};
  endfunction

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic [BASE_W:0] res;
      res          = div_step({rem[i], quot[i][DW-1]}, base);
      quot_next[i] = {quot[i][DW-2:0], res[BASE_W]};
      rem_next[i]  = res[BASE_W-1:0];
    end
  end

  // The running residue stays below the base, so this sum fits in SUM_W bits.
  assign sum = SUM_W'(rem[2]) + prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= BASE_RST;
    end else if (cfg_wr_en) begin
      base <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot[0] <= DW'(left_operand);
      quot[1] <= DW'(right_operand);
      quot[2] <= '0;
      for (int i = 0; i < LANES; i++) begin
        rem[i] <= '0;
      end
      cnt <= '0;
    end else if (cmd.next_pass) begin
      quot[2] <= DW'(sum);
      for (int i = 0; i < LANES; i++) begin
        rem[i] <= '0;
      end
      cnt <= '0;
    end else if (cmd.step) begin
      for (int i = 0; i < LANES; i++) begin
        quot[i] <= quot_next[i];
        rem[i]  <= rem_next[i];
      end
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.load) begin
      prod <= '0;
    end else if (cmd.mul) begin
      prod <= {{(SUM_W-BASE_W){1'b0}}, rem[0]} * {{(SUM_W-BASE_W){1'b0}}, rem[1]};
    end
    if (cmd.store_out) begin
      digit_sum <= rem[2];
    end
  end

  assign stat.trivial   = (base < MIN_BASE) || (left_operand == '0) || (right_operand == '0);
  assign stat.last_step = (cnt == CNT_W'(DW - 1));
  assign stat.quot_zero = (quot[0] == '0) || (quot[1] == '0);

endmodule

`default_nettype wire

>>> design/dpsm_ctrl.sv
`default_nettype none

module dpsm_ctrl
  import dpsm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dpsm_stat_t stat,
  output dpsm_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PASS = 5'b00010,
    S_MUL  = 5'b00100,
    S_NEXT = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   final_pass, final_pass_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    final_pass_next = final_pass;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load        = 1'b1;
          final_pass_next = 1'b0;
          state_next      = stat.trivial ? S_FIN : S_PASS;
        end
      end
      S_PASS: begin
        cmd.step = 1'b1;
        if (stat.last_step) begin
          state_next = final_pass ? S_FIN : S_MUL;
        end
      end
      S_MUL: begin
        // A zero quotient means the digit just produced was the last one.
        cmd.mul         = 1'b1;
        final_pass_next = stat.quot_zero;
        state_next      = S_NEXT;
      end
      S_NEXT: begin
        cmd.next_pass = 1'b1;
        state_next    = S_PASS;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.store_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.store_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      final_pass <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      final_pass <= final_pass_next;
      out_valid  <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> design/digit_product_sum_mod_top.sv
`default_nettype none

// Splits both operands into digits of the configured base, least significant
// first, multiplies digits of equal position and returns their sum modulo the
// base; digits stop as soon as either quotient reaches zero. One transaction
// is worked at a time. Every digit costs a division pass over DW bits,
// DW = max(OPERAND_WIDTH, 32), through a three-lane shift-subtract divider
// (both operands plus the reduction of the running sum), plus a multiply
// step and a reload step; an item with D digits takes D+1 passes, the last
// one reducing the final sum. An item with a zero operand or a base below
// two skips the passes and yields zero. The result sits in an output register,
// so a new transaction can be accepted while it waits. Write the base only
// while the block is idle.
module digit_product_sum_mod_top
  import dpsm_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [BASE_W-1:0] cfg_wr_data,
  dpsm_in_if.sink                in_ch,
  dpsm_out_if.source             out_ch
);

  dpsm_cmd_t  cmd;
  dpsm_stat_t stat;
  logic       in_ready;
  logic       out_valid;
  logic [BASE_W-1:0] digit_sum;

  dpsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dpsm_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .left_operand  (in_ch.left_operand),
    .right_operand (in_ch.right_operand),
    .cmd           (cmd),
    .stat          (stat),
    .digit_sum     (digit_sum)
  );

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid;
  assign out_ch.digit_sum = digit_sum;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import dpsm_pkg::*;

  localparam int OPERAND_WIDTH = 32;
  localparam int CYCLE_LIMIT   = 2_500_000;
  localparam int BATCH_ITEMS   = 45;
  localparam int STALL_CYCLES  = 3000;
  localparam int DRAIN_CYCLES  = 1200;

  typedef logic [OPERAND_WIDTH-1:0] operand_t;

  typedef struct {
    operand_t left;
    operand_t right;
  } operand_pair_t;

  typedef struct {
    operand_t          left;
    operand_t          right;
    logic [BASE_W-1:0] base;
    logic [15:0]       sum;
  } due_sum_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [BASE_W-1:0] cfg_wr_data = '0;

  dpsm_in_if #(.OPERAND_WIDTH(OPERAND_WIDTH)) in_ch ();
  dpsm_out_if out_ch ();

  digit_product_sum_mod_top #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  operand_pair_t     pending_pairs[$];
  due_sum_t          sums_due[$];
  operand_pair_t     next_pair;
  due_sum_t          accepted_sum;
  due_sum_t          oldest_sum;
  logic [BASE_W-1:0] base_now = BASE_RST;
  int                send_idle_pct = 14;
  int                recv_idle_pct = 64;
  int                queued_count = 0;
  int                checked_count = 0;
  int                error_count = 0;
  int                base_count = 1;
  int                cycle_count = 0;
  bit                stall_arm = 1'b0;
  bit                stall_fired = 1'b0;
  int                stall_left = 0;

  always #5 clk = ~clk;

  // Sum of same-position digit products modulo the base, digits taken until
  // either quotient runs out.
  function automatic logic [15:0] digit_product_sum(operand_t left, operand_t right,
                                                    logic [BASE_W-1:0] base);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] m;
    logic [63:0] acc;
    logic [63:0] da;
    logic [63:0] db;
    a = 64'(left);
    b = 64'(right);
    m = 64'(base);
    acc = 0;
    if (m >= 2) begin
      while (a != 0 && b != 0) begin
        da = a % m;
        db = b % m;
        a = a / m;
        b = b / m;
        acc = (acc + da * db) % m;
      end
    end
    return acc[15:0];
  endfunction

  function automatic operand_t rand_operand();
    operand_t v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      2, 3: v = operand_t'($urandom) >> $urandom_range(OPERAND_WIDTH - 1);
      default: v = operand_t'($urandom);
    endcase
    return v;
  endfunction

  // Driver: a transaction is offered from the pending queue and the expected
  // sum is recorded at the edge where it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        accepted_sum.left  = in_ch.left_operand;
        accepted_sum.right = in_ch.right_operand;
        accepted_sum.base  = base_now;
        accepted_sum.sum   = digit_product_sum(in_ch.left_operand, in_ch.right_operand,
                                               base_now);
        sums_due.push_back(accepted_sum);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_pair = pending_pairs.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.left_operand  <= next_pair.left;
          in_ch.right_operand <= next_pair.right;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off of the output side, counted here.
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (stall_arm && !stall_fired) begin
      stall_left  <= STALL_CYCLES;
      stall_fired <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Monitor: each accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (sums_due.size() == 0) begin
          $display("%0t: result %0d arrived with no transaction outstanding",
                   $time, out_ch.digit_sum);
          error_count++;
        end else begin
          oldest_sum = sums_due.pop_front();
          if (out_ch.digit_sum !== oldest_sum.sum) begin
            $display("%0t: digit_sum mismatch for %h, %h base %0d: expected %0d actual %0d",
                     $time, oldest_sum.left, oldest_sum.right, oldest_sum.base,
                     oldest_sum.sum, out_ch.digit_sum);
            error_count++;
          end
        end
        checked_count++;
      end
      out_ch.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sums_due.size());
      $display("FAIL digit_product_sum_mod_top");
      $finish;
    end
  end

  task automatic send_pair(operand_t left, operand_t right);
    operand_pair_t p;
    p.left  = left;
    p.right = right;
    pending_pairs.push_back(p);
    queued_count++;
  endtask

  task automatic wait_drained();
    while (checked_count != queued_count) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_base(logic [BASE_W-1:0] base);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= base;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    base_now = base;
    base_count++;
  endtask

  task automatic run_random_batch(logic [BASE_W-1:0] base);
    set_base(base);
    for (int i = 0; i < BATCH_ITEMS; i++) send_pair(rand_operand(), rand_operand());
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.left_operand  = '0;
    in_ch.right_operand = '0;
    out_ch.ready        = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items at the reset base of two.
    send_pair('0, '0);
    send_pair('0, '1);
    send_pair('1, '0);
    send_pair('1, '1);
    send_pair(32'd1, 32'd1);
    send_pair(32'd1, '1);
    send_pair('1, 32'd1);
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555);
    send_pair(32'hAAAA_AAAA, 32'hAAAA_AAAA);
    send_pair(32'h1234_5678, 32'h8765_4321);

    // Largest base: largest digits and their product.
    set_base(16'hFFFF);
    send_pair('1, '1);
    send_pair(32'd65534, 32'd65534);
    send_pair(32'hFFFE_FFFE, 32'hFFFE_FFFE);
    send_pair(32'd0, 32'd5);
    send_pair(32'd7, 32'd0);

    // A base below two takes no digits at all.
    set_base(16'd0);
    send_pair('1, 32'd3);
    send_pair(32'd5, 32'd5);
    set_base(16'd1);
    send_pair('1, '1);
    send_pair(32'd9, 32'd9);

    run_random_batch(16'd2);
    run_random_batch(16'd3);
    run_random_batch(16'd10);
    run_random_batch(16'd256);

    send_idle_pct = 64;
    recv_idle_pct = 14;
    set_base(16'hFFFF);
    // Fast items at the largest base, so the block backs up behind the stall.
    stall_arm = 1'b1;
    for (int i = 0; i < BATCH_ITEMS; i++) send_pair(rand_operand(), rand_operand());
    run_random_batch(16'hFFFE);
    run_random_batch(BASE_W'($urandom_range(65535, 2)));
    run_random_batch(BASE_W'($urandom_range(65535, 2)));

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_batch(BASE_W'($urandom_range(65535, 2)));
    run_random_batch(BASE_W'($urandom_range(255, 2)));
    run_random_batch(16'd7);
    run_random_batch(16'd16);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d digit product sums over %0d base settings, from 0 up to 65535.",
             checked_count, base_count);
    $display("Idling shifted between sender and receiver, with one %0d-cycle output stall.",
             STALL_CYCLES);
    if (error_count == 0 && sums_due.size() == 0) begin
      $display("PASS digit_product_sum_mod_top");
    end else begin
      $display("%0d mismatches, %0d results never arrived", error_count, sums_due.size());
      $display("FAIL digit_product_sum_mod_top");
    end
    $finish;
  end

endmodule
